[src/msds_pkg.sv]
`default_nettype none
package msds_pkg;

    localparam int EDID_BYTES_DEFAULT = 128;

    localparam int PIN_W  = 16;
    localparam int IDX_W  = 7;
    localparam int BYTE_W = 8;
    localparam int STD_W  = 3;
    localparam int EXT_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam int SCL_BIT = 12;
    localparam int SDA_BIT = 13;

    localparam logic [PIN_W-1:0] SENSE_MASK = 16'h3100;
    localparam logic [PIN_W-1:0] DIR_NONE   = 16'h0000;
    localparam logic [PIN_W-1:0] DIR_SDA    = 16'h2000;
    localparam logic [PIN_W-1:0] DIR_SCL    = 16'h1000;
    localparam logic [PIN_W-1:0] DIR_AUX    = 16'h0100;
    localparam logic [PIN_W-1:0] MULTI_DRIVE = 16'h3100;

    localparam logic [BYTE_W-1:0] DEV_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] SLAVE_ID = 8'hA0;

    localparam logic [CFG_IDX_W-1:0] CFG_STANDARD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENDED = 1'b1;

    typedef enum logic [4:0] {
        PH_STOP = 5'b00001,
        PH_ACK  = 5'b00010,
        PH_DEV  = 5'b00100,
        PH_REG  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

endpackage
`default_nettype wire

[src/msds_access_if.sv]
`default_nettype none
interface msds_access_if;
    import msds_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [PIN_W-1:0]  pin_data;
    logic [PIN_W-1:0]  pin_dirs;
    logic [IDX_W-1:0]  table_index;
    logic [BYTE_W-1:0] table_byte;

    modport source (output valid, op, pin_data, pin_dirs, table_index, table_byte,
                    input ready);
    modport sink (input valid, op, pin_data, pin_dirs, table_index, table_byte,
                  output ready);
endinterface
`default_nettype wire

[src/msds_result_if.sv]
`default_nettype none
interface msds_result_if;
    import msds_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] sense_value;

    modport source (output valid, sense_value, input ready);
    modport sink (input valid, sense_value, output ready);
endinterface
`default_nettype wire

[src/msds_cfg_if.sv]
`default_nettype none
interface msds_cfg_if;
    import msds_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/monitor_sense_ddc_slave_core.sv]
`default_nettype none
// Channel   Modport  Payload                                          Transaction
// access    sink     op, pin_data, pin_dirs, table_index, table_byte   valid & ready
// result    source   sense_value                                      valid & ready
// cfg       sink     index, data                                      valid & ready (always ready)
//
// One item per cycle unless the skid register is full; each result is registered.
// A result register plus a skid register hold up to two results under output stall;
// access.ready drops only while the skid register is full.
// EDID bytes fetched from the table memory land in its read register in the next cycle.
// rst_n resets all control state; the EDID table is undefined until loaded.
module monitor_sense_ddc_slave_core #(
    parameter int EDID_BYTES = msds_pkg::EDID_BYTES_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    msds_access_if.sink   access,
    msds_result_if.source result,
    msds_cfg_if.sink      cfg
);
    import msds_pkg::*;

    localparam int PTR_W = $clog2(EDID_BYTES);

    logic [STD_W-1:0] std_code_reg;
    logic [EXT_W-1:0] ext_code_reg;

    logic              ddc_en_reg, ddc_en_next;
    logic              prior_sda_reg, prior_sda_next;
    logic              prior_scl_reg, prior_scl_next;
    phase_t            phase_reg, phase_next;
    phase_t            pba_reg, pba_next;
    logic [2:0]        bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              shift_mem_reg, shift_mem_next;
    logic [BYTE_W-1:0] dev_id_reg, dev_id_next;
    logic [BYTE_W-1:0] offset_reg, offset_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;

    logic [BYTE_W-1:0] edid_mem [EDID_BYTES];
    logic [BYTE_W-1:0] mem_rdata_reg;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic              wr_en;

    logic             out_v_reg, skid_v_reg;
    logic [PIN_W-1:0] out_reg, skid_reg;
    logic [PIN_W-1:0] item_value;

    logic in_fire, out_fire;
    logic scl_in, sda_in, sda_out, magic, rose;
    logic [BYTE_W-1:0] shift_cur, shifted;
    logic [PIN_W-1:0]  legacy_value;

    assign cfg.ready     = 1'b1;
    assign access.ready  = !skid_v_reg;
    assign in_fire       = access.valid && access.ready;
    assign out_fire      = result.valid && result.ready;
    assign result.valid  = out_v_reg;
    assign result.sense_value = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_code_reg <= STD_W'(6);
            ext_code_reg <= EXT_W'(43);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_STANDARD: std_code_reg <= cfg.data[STD_W-1:0];
                CFG_EXTENDED: ext_code_reg <= cfg.data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (access.pin_dirs & SENSE_MASK)
            DIR_NONE: legacy_value = {2'b00, std_code_reg[2:1], 3'b000, std_code_reg[0], 8'h00};
            DIR_SDA:  legacy_value = {3'b000, ext_code_reg[5], 3'b000, ext_code_reg[4], 8'h00};
            DIR_SCL:  legacy_value = {2'b00, ext_code_reg[3], 4'b0000, ext_code_reg[2], 8'h00};
            DIR_AUX:  legacy_value = {2'b00, ext_code_reg[1], ext_code_reg[0], 12'h000};
            default:  legacy_value = MULTI_DRIVE;
        endcase
    end

    assign scl_in = access.pin_dirs[SCL_BIT] ? access.pin_data[SCL_BIT] : 1'b1;
    assign sda_in = access.pin_dirs[SDA_BIT] ? access.pin_data[SDA_BIT] : 1'b1;
    assign magic  = ((access.pin_dirs & SENSE_MASK) == DIR_NONE)
                 && ((access.pin_data & SENSE_MASK) == SENSE_MASK);
    assign shift_cur = shift_mem_reg ? mem_rdata_reg : shift_reg;
    assign shifted   = {shift_cur[BYTE_W-2:0], prior_sda_reg};
    assign rose      = (scl_in != prior_scl_reg) && scl_in;

    always_comb
    begin
        ddc_en_next    = ddc_en_reg;
        prior_sda_next = prior_sda_reg;
        prior_scl_next = prior_scl_reg;
        phase_next     = phase_reg;
        pba_next       = pba_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        shift_mem_next = shift_mem_reg;
        dev_id_next    = dev_id_reg;
        offset_next    = offset_reg;
        ptr_next       = ptr_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        sda_out        = sda_in;
        item_value     = '0;

        if (in_fire)
        begin
            if (access.op)
            begin
                wr_en = 1'b1;
            end
            else if (!ddc_en_reg || magic)
            begin
                ddc_en_next = 1'b0;
                item_value  = legacy_value;
            end
            else
            begin
                if (sda_in != prior_sda_reg)
                begin
                    if (scl_in)
                    begin
                        if (!sda_in)
                        begin
                            phase_next   = PH_DEV;
                            bit_cnt_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                end
                else if (rose)
                begin
                    case (phase_reg)
                        PH_ACK:
                        begin
                            bit_cnt_next   = '0;
                            shift_next     = '0;
                            shift_mem_next = 1'b0;
                            case (pba_reg)
                                PH_DEV:
                                begin
                                    sda_out = ((dev_id_reg & DEV_MASK) == SLAVE_ID) ? 1'b0 : 1'b1;
                                    if (dev_id_reg[0])
                                    begin
                                        phase_next     = PH_DATA;
                                        rd_en          = 1'b1;
                                        rd_addr        = '0;
                                        ptr_next       = PTR_W'(1);
                                        shift_mem_next = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_REG;
                                    end
                                end
                                PH_REG:
                                begin
                                    phase_next = PH_DATA;
                                    sda_out    = (offset_reg != '0);
                                end
                                PH_DATA:
                                begin
                                    phase_next = PH_DATA;
                                    if (dev_id_reg[0])
                                    begin
                                        if (!sda_in)
                                        begin
                                            rd_en          = 1'b1;
                                            rd_addr        = ptr_reg;
                                            shift_mem_next = 1'b1;
                                            ptr_next = (ptr_reg == PTR_W'(EDID_BYTES - 1))
                                                     ? '0 : ptr_reg + PTR_W'(1);
                                        end
                                    end
                                    else
                                    begin
                                        sda_out = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        PH_DEV, PH_REG:
                        begin
                            shift_next     = shifted;
                            shift_mem_next = 1'b0;
                            if (bit_cnt_reg == 3'd7)
                            begin
                                bit_cnt_next = '0;
                                pba_next     = phase_reg;
                                phase_next   = PH_ACK;
                                if (phase_reg == PH_DEV)
                                    dev_id_next = shifted;
                                else
                                    offset_next = shifted;
                            end
                            else
                            begin
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                            end
                        end
                        PH_DATA:
                        begin
                            sda_out = shift_cur[3'd7 - bit_cnt_reg];
                            if (bit_cnt_reg == 3'd7)
                            begin
                                bit_cnt_next = '0;
                                pba_next     = PH_DATA;
                                phase_next   = PH_ACK;
                            end
                            else
                            begin
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                prior_sda_next = sda_out;
                prior_scl_next = scl_in;
                item_value = '0;
                item_value[SDA_BIT] = sda_out;
                item_value[SCL_BIT] = scl_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            edid_mem[PTR_W'(access.table_index)] <= access.table_byte;
        if (rd_en)
            mem_rdata_reg <= edid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ddc_en_reg    <= 1'b1;
            prior_sda_reg <= 1'b1;
            prior_scl_reg <= 1'b1;
            phase_reg     <= PH_STOP;
            pba_reg       <= PH_STOP;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            shift_mem_reg <= 1'b0;
            dev_id_reg    <= '0;
            offset_reg    <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            ddc_en_reg    <= ddc_en_next;
            prior_sda_reg <= prior_sda_next;
            prior_scl_reg <= prior_scl_next;
            phase_reg     <= phase_next;
            pba_reg       <= pba_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            shift_mem_reg <= shift_mem_next;
            dev_id_reg    <= dev_id_next;
            offset_reg    <= offset_next;
            ptr_reg       <= ptr_next;
        end
    end

    // drain skid first, park new result in skid while output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_fire || !out_v_reg)
        begin
            out_v_reg  <= skid_v_reg || in_fire;
            skid_v_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire || !out_v_reg)
            out_reg <= skid_v_reg ? skid_reg : item_value;
        else if (in_fire)
            skid_reg <= item_value;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while result register empty");

    a_ddc_off_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !ddc_en_reg |=> !ddc_en_reg)
        else $error("DDC mode re-enabled without reset");

    a_fetch_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> shift_mem_reg)
        else $error("fetched EDID byte not selected as shift byte");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(EDID_BYTES - 1))
        else $error("read pointer beyond EDID table");

    a_ack_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ACK) |-> (bit_cnt_reg == 3'd0))
        else $error("bit counter running during acknowledge");

endmodule
`default_nettype wire
